FILE: sv/trm_pkg.sv
// ============================================================================
// trm_pkg: shared definitions for the NCHW max-reduction core
// Field widths, register indexes, reduce modes, the setup sequencer states
// and the float compare used by the accumulator.
// ============================================================================
package trm_pkg;

    localparam int ELEM_W     = 32;
    localparam int COUNT_W    = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] REG_REDUCE_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BATCH_COUNT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT  = 3'd4;

    localparam logic [2:0] MODE_N   = 3'd0;
    localparam logic [2:0] MODE_C   = 3'd1;
    localparam logic [2:0] MODE_H   = 3'd2;
    localparam logic [2:0] MODE_W   = 3'd3;
    localparam logic [2:0] MODE_ALL = 3'd4;
    localparam logic [2:0] MODE_NC  = 3'd5;
    localparam logic [2:0] MODE_CH  = 3'd6;
    localparam logic [2:0] MODE_HW  = 3'd7;

    typedef enum logic [1:0] {
        SETUP_IDLE,
        SETUP_W,
        SETUP_H,
        SETUP_C
    } trm_setup_t;

    typedef struct packed {
        logic first;
        logic done;
        logic last;
    } trm_flags_t;

    // Bit 3 reduces n, bit 2 c, bit 1 h, bit 0 w.
    function automatic logic [3:0] axis_mask(input logic [2:0] mode);
        logic [3:0] m;
        case (mode)
            MODE_N:   m = 4'b1000;
            MODE_C:   m = 4'b0100;
            MODE_H:   m = 4'b0010;
            MODE_W:   m = 4'b0001;
            MODE_ALL: m = 4'b1111;
            MODE_NC:  m = 4'b1100;
            MODE_CH:  m = 4'b0110;
            MODE_HW:  m = 4'b0011;
            default:  m = 4'b1000;
        endcase
        return m;
    endfunction

    function automatic logic float_gt(input logic [ELEM_W-1:0] a, input logic [ELEM_W-1:0] b);
        logic r;
        if (a[31] != b[31]) begin
            r = b[31];
        end else if (!a[31]) begin
            r = a[30:0] > b[30:0];
        end else begin
            r = a[30:0] < b[30:0];
        end
        return r;
    endfunction

endpackage

FILE: sv/trm_if.sv
// ============================================================================
// trm_if: channel interfaces of the NCHW max-reduction core
// Element input stream, result output stream and configuration write channel.
// ============================================================================
interface trm_in_if import trm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ELEM_W-1:0] element_bits;
    modport source (output valid, output element_bits, input ready);
    modport sink (input valid, input element_bits, output ready);
endinterface

interface trm_out_if import trm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ELEM_W-1:0] max_bits;
    logic              final_result;
    modport source (output valid, output max_bits, output final_result, input ready);
    modport sink (input valid, input max_bits, input final_result, output ready);
endinterface

interface trm_cfg_if import trm_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

FILE: sv/trm_addr_gen.sv
// ============================================================================
// trm_addr_gen: coordinates, strides and accumulator address
// Holds the configuration, computes the output strides modulo the depth with
// a bit-serial multiplier after each write, and walks the tensor coordinates.
// ============================================================================
module trm_addr_gen import trm_pkg::*; #(
    parameter int ACC_DEPTH = 4096,
    parameter int MAX_DIM   = 4096
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_fire,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  accept,
    output logic                  setup_idle,
    output logic [(ACC_DEPTH > 1 ? $clog2(ACC_DEPTH) : 1)-1:0] addr,
    output trm_flags_t            flags
);

    localparam int AW   = ACC_DEPTH > 1 ? $clog2(ACC_DEPTH) : 1;
    localparam int DW   = $clog2(MAX_DIM + 1) > 0 ? $clog2(MAX_DIM + 1) : 1;
    localparam int PW   = MAX_DIM > 1 ? $clog2(MAX_DIM) : 1;
    localparam int XW   = DW > COUNT_W ? DW : COUNT_W;
    localparam int CNTW = $clog2(DW + 1);
    localparam logic [AW:0]   DEPTH_V = (AW + 1)'(ACC_DEPTH);
    localparam logic [AW-1:0] ONE_MOD = AW'(ACC_DEPTH > 1 ? 1 : 0);

    function automatic logic [AW-1:0] mod_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
        logic [AW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= DEPTH_V) begin
            s = s - DEPTH_V;
        end
        return s[AW-1:0];
    endfunction

    logic [2:0]         mode_reg;
    logic [COUNT_W-1:0] cnt_reg [4];
    logic [DW-1:0]      dim [4];
    logic [DW-1:0]      kext [4];
    logic [3:0]         reduced;
    logic [3:0]         at_end;
    logic [AW-1:0]      stride [4];

    trm_setup_t    state_reg, state_next;
    logic [DW-1:0] mul_a_reg;
    logic [AW-1:0] mul_b_reg, prod_reg, prod_step;
    logic [CNTW-1:0] bit_cnt_reg;
    logic [AW-1:0] s_reg [3];
    logic [DW-1:0] load_a;
    logic [AW-1:0] load_b;

    logic [PW-1:0] pos_reg [4], pos_next [4];
    logic [AW-1:0] off_reg [4], off_next [4];
    logic          cfg_hit;

    assign cfg_hit = cfg_fire && (cfg_index <= REG_COLUMN_COUNT);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            mode_reg <= MODE_N;
            for (int i = 0; i < 4; i++) begin
                cnt_reg[i] <= COUNT_W'(1);
            end
        end else if (cfg_fire) begin
            case (cfg_index)
                REG_REDUCE_MODE:   mode_reg   <= cfg_data[2:0];
                REG_BATCH_COUNT:   cnt_reg[0] <= cfg_data;
                REG_CHANNEL_COUNT: cnt_reg[1] <= cfg_data;
                REG_ROW_COUNT:     cnt_reg[2] <= cfg_data;
                REG_COLUMN_COUNT:  cnt_reg[3] <= cfg_data;
                default:           ;
            endcase
        end
    end

    always_comb begin
        logic [3:0]    m;
        logic [XW-1:0] ext;
        m = axis_mask(mode_reg);
        for (int i = 0; i < 4; i++) begin
            reduced[i] = m[3-i];
            ext = XW'(cnt_reg[i]);
            if (ext == '0) begin
                dim[i] = DW'(1);
            end else if (ext > XW'(MAX_DIM)) begin
                dim[i] = DW'(MAX_DIM);
            end else begin
                dim[i] = DW'(ext);
            end
            kext[i] = reduced[i] ? DW'(1) : dim[i];
            at_end[i] = (DW'(pos_reg[i]) + DW'(1)) == dim[i];
        end
    end

    always_comb begin
        stride[3] = reduced[3] ? '0 : ONE_MOD;
        for (int i = 0; i < 3; i++) begin
            stride[i] = reduced[i] ? '0 : s_reg[i];
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            SETUP_W:  if (bit_cnt_reg == CNTW'(1)) state_next = SETUP_H;
            SETUP_H:  if (bit_cnt_reg == CNTW'(1)) state_next = SETUP_C;
            SETUP_C:  if (bit_cnt_reg == CNTW'(1)) state_next = SETUP_IDLE;
            default:  state_next = SETUP_IDLE;
        endcase
        if (cfg_hit) begin
            state_next = SETUP_W;
        end
    end

    always_comb begin
        logic [AW-1:0] t;
        setup_idle = state_reg == SETUP_IDLE;
        case (state_reg)
            SETUP_W: begin
                load_a = kext[3];
                load_b = ONE_MOD;
            end
            SETUP_H: begin
                load_a = kext[2];
                load_b = s_reg[2];
            end
            SETUP_C: begin
                load_a = kext[1];
                load_b = s_reg[1];
            end
            default: begin
                load_a = '0;
                load_b = '0;
            end
        endcase
        t = mod_add(prod_reg, prod_reg);
        prod_step = mul_a_reg[DW-1] ? mod_add(t, mul_b_reg) : t;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg   <= SETUP_W;
            bit_cnt_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_hit || state_next != state_reg || state_reg == SETUP_IDLE) begin
                bit_cnt_reg <= '0;
            end else if (bit_cnt_reg == '0) begin
                bit_cnt_reg <= CNTW'(DW);
            end else begin
                bit_cnt_reg <= bit_cnt_reg - CNTW'(1);
            end
        end
    end

    always_ff @(posedge clk) begin
        if (bit_cnt_reg == '0) begin
            mul_a_reg <= load_a;
            mul_b_reg <= load_b;
            prod_reg  <= '0;
        end else begin
            mul_a_reg <= mul_a_reg << 1;
            prod_reg  <= prod_step;
            if (bit_cnt_reg == CNTW'(1)) begin
                case (state_reg)
                    SETUP_W: s_reg[2] <= prod_step;
                    SETUP_H: s_reg[1] <= prod_step;
                    SETUP_C: s_reg[0] <= prod_step;
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        logic carry;
        carry = 1'b1;
        for (int i = 3; i >= 0; i--) begin
            pos_next[i] = pos_reg[i];
            off_next[i] = off_reg[i];
            if (carry) begin
                if (at_end[i]) begin
                    pos_next[i] = '0;
                    off_next[i] = '0;
                end else begin
                    pos_next[i] = PW'(pos_reg[i] + PW'(1));
                    off_next[i] = mod_add(off_reg[i], stride[i]);
                    carry = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int i = 0; i < 4; i++) begin
                pos_reg[i] <= '0;
                off_reg[i] <= '0;
            end
        end else if (cfg_hit) begin
            for (int i = 0; i < 4; i++) begin
                pos_reg[i] <= '0;
                off_reg[i] <= '0;
            end
        end else if (accept) begin
            pos_reg <= pos_next;
            off_reg <= off_next;
        end
    end

    always_comb begin
        logic f;
        logic d;
        f = 1'b1;
        d = 1'b1;
        for (int i = 0; i < 4; i++) begin
            if (reduced[i] && pos_reg[i] != '0) f = 1'b0;
            if (reduced[i] && !at_end[i]) d = 1'b0;
        end
        flags.first = f;
        flags.done  = d;
        flags.last  = &at_end;
        addr = mod_add(mod_add(off_reg[0], off_reg[1]), mod_add(off_reg[2], off_reg[3]));
    end

    a_no_accept_in_setup: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> state_reg == SETUP_IDLE)
        else $error("element accepted during stride setup");

    a_cfg_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_hit |=> (pos_reg[0] == '0 && pos_reg[1] == '0 && pos_reg[2] == '0
                     && pos_reg[3] == '0))
        else $error("configuration write did not restart the tensor");

    a_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, addr} < DEPTH_V)
        else $error("accumulator address out of range");

    a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
        flags.last |-> flags.done)
        else $error("last element of tensor does not complete a position");

endmodule

FILE: sv/trm_acc.sv
// ============================================================================
// trm_acc: accumulator memory with compare and result register
// Reads the running maximum at accept, compares in the next stage with
// forwarding of the latest write, writes back, and holds the result beat.
// ============================================================================
module trm_acc import trm_pkg::*; #(
    parameter int ACC_DEPTH = 4096
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [ELEM_W-1:0] x,
    input  logic [(ACC_DEPTH > 1 ? $clog2(ACC_DEPTH) : 1)-1:0] addr,
    input  trm_flags_t        flags,
    output logic              acc_ready,
    trm_out_if.source         out_stream
);

    localparam int AW = ACC_DEPTH > 1 ? $clog2(ACC_DEPTH) : 1;

    logic [ELEM_W-1:0] mem [ACC_DEPTH];
    logic [ELEM_W-1:0] rdata_reg;

    logic              b_valid_reg;
    logic [ELEM_W-1:0] b_x_reg;
    logic [AW-1:0]     b_addr_reg;
    trm_flags_t        b_flags_reg;

    logic              fwd_valid_reg;
    logic [AW-1:0]     fwd_addr_reg;
    logic [ELEM_W-1:0] fwd_data_reg;

    logic              out_valid_reg;
    logic [ELEM_W-1:0] out_bits_reg;
    logic              out_final_reg;

    logic [ELEM_W-1:0] old_val, new_val;
    logic              out_free, b_fire;

    always_comb begin
        old_val  = (fwd_valid_reg && fwd_addr_reg == b_addr_reg) ? fwd_data_reg : rdata_reg;
        new_val  = (b_flags_reg.first || !float_gt(old_val, b_x_reg)) ? b_x_reg : old_val;
        out_free = !out_valid_reg || out_stream.ready;
        b_fire   = b_valid_reg && (!b_flags_reg.done || out_free);
        acc_ready = !b_valid_reg || b_fire;
    end

    always_ff @(posedge clk) begin
        if (accept) begin
            rdata_reg <= mem[addr];
        end
        if (b_fire) begin
            mem[b_addr_reg] <= new_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            b_valid_reg   <= 1'b0;
            fwd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                b_valid_reg <= 1'b1;
            end else if (b_fire) begin
                b_valid_reg <= 1'b0;
            end
            if (b_fire) begin
                fwd_valid_reg <= 1'b1;
            end
            if (b_fire && b_flags_reg.done) begin
                out_valid_reg <= 1'b1;
            end else if (out_stream.ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (accept) begin
            b_x_reg     <= x;
            b_addr_reg  <= addr;
            b_flags_reg <= flags;
        end
        if (b_fire) begin
            fwd_addr_reg <= b_addr_reg;
            fwd_data_reg <= new_val;
        end
        if (b_fire && b_flags_reg.done) begin
            out_bits_reg  <= new_val;
            out_final_reg <= b_flags_reg.last;
        end
    end

    assign out_stream.valid        = out_valid_reg;
    assign out_stream.max_bits     = out_bits_reg;
    assign out_stream.final_result = out_final_reg;

endmodule

FILE: sv/tensor_reduce_max_nchw_core.sv
// ============================================================================
// tensor_reduce_max_nchw_core: streaming max-reduction of an NCHW tensor
// Top level joining the address generator and the accumulator stage.
// ============================================================================
// Elements enter one beat per cycle in NCHW order while in_stream.ready is
// high; a result beat passes the compare stage and the output register after
// the element that completes its output position, with final_result set on
// the last one of the tensor. The accumulator memory is read at accept and
// written back from the compare stage with the latest write forwarded, so the
// core sustains one element per cycle while the output takes its results. After
// reset and each register write, stride setup (SETUP_W/H/C) holds off input.
module tensor_reduce_max_nchw_core import trm_pkg::*; #(
    parameter int ACC_DEPTH = 4096,
    parameter int MAX_DIM   = 4096
) (
    input  logic      clk,
    input  logic      rst_n,
    trm_cfg_if.sink   cfg,
    trm_in_if.sink    in_stream,
    trm_out_if.source out_stream
);

    localparam int AW = ACC_DEPTH > 1 ? $clog2(ACC_DEPTH) : 1;

    logic          setup_idle, acc_ready, accept, cfg_fire;
    logic [AW-1:0] addr;
    trm_flags_t    flags;

    assign cfg.ready       = 1'b1;
    assign cfg_fire        = cfg.valid && cfg.ready;
    assign in_stream.ready = setup_idle && acc_ready;
    assign accept          = in_stream.valid && in_stream.ready;

    trm_addr_gen #(
        .ACC_DEPTH (ACC_DEPTH),
        .MAX_DIM   (MAX_DIM)
    ) u_addr_gen (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_fire   (cfg_fire),
        .cfg_index  (cfg.index),
        .cfg_data   (cfg.data),
        .accept     (accept),
        .setup_idle (setup_idle),
        .addr       (addr),
        .flags      (flags)
    );

    trm_acc #(
        .ACC_DEPTH (ACC_DEPTH)
    ) u_acc (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .x          (in_stream.element_bits),
        .addr       (addr),
        .flags      (flags),
        .acc_ready  (acc_ready),
        .out_stream (out_stream)
    );

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// ============================================================================
// testbench: self-checking bench for tensor_reduce_max_nchw_core
// Streams float32 NCHW tensors through the core under a range of reduce
// modes and shapes, predicts every running maximum in step with the input
// beats, and compares each result beat against the oldest expected one.
// ============================================================================
module testbench;
    import trm_pkg::*;

    localparam int  STORE_DEPTH = 4096;
    localparam int  DIM_LIMIT   = 4096;
    localparam int  CYCLE_LIMIT = 1000000;
    localparam int  HOLD_CYCLES = 300;
    localparam int  SETTLE      = 8;

    typedef struct {
        logic [ELEM_W-1:0] max_bits;
        logic              final_result;
    } max_result_t;

    typedef struct {
        logic [ELEM_W-1:0] element_bits;
        logic [ELEM_W-1:0] max_bits;
    } directed_row_t;

    logic clk;
    logic rst_n;
    int   cycle_count;
    int   error_count;
    int   items_sent;
    int   results_seen;
    int   config_count;
    int   idle_in_pct;
    int   idle_out_pct;
    bit   hold_request;

    max_result_t       pending_max[$];
    logic [ELEM_W-1:0] max_store [STORE_DEPTH];
    int unsigned       coord [4];
    logic [2:0]        mode_reg;
    logic [12:0]       count_reg [4];

    trm_cfg_if cfg_if ();
    trm_in_if  in_if ();
    trm_out_if out_if ();

    tensor_reduce_max_nchw_core u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_if.sink),
        .in_stream  (in_if.sink),
        .out_stream (out_if.source)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic int unsigned clamp_dim(input logic [12:0] v);
        if (v == 13'd0)
            return 1;
        if (v > DIM_LIMIT)
            return DIM_LIMIT;
        return 32'(v);
    endfunction

    function automatic logic [3:0] reduced_axes(input logic [2:0] m);
        case (m)
            MODE_N:   return 4'b1000;
            MODE_C:   return 4'b0100;
            MODE_H:   return 4'b0010;
            MODE_W:   return 4'b0001;
            MODE_ALL: return 4'b1111;
            MODE_NC:  return 4'b1100;
            MODE_CH:  return 4'b0110;
            default:  return 4'b0011;
        endcase
    endfunction

    // Maps a float onto an unsigned key with the same ordering.
    function automatic logic [31:0] order_key(input logic [31:0] f);
        return f[31] ? ~f : (f | 32'h8000_0000);
    endfunction

    function automatic void update_max(input logic [ELEM_W-1:0] x, output bit emits,
                                       output max_result_t res);
        int unsigned     dims [4];
        int unsigned     pos [4];
        int unsigned     kext [4];
        int unsigned     kpos [4];
        logic [3:0]      mask;
        bit              first;
        bit              done;
        bit              last_all;
        bit              at_end;
        longint unsigned out_index;
        int unsigned     addr;
        logic [31:0]     acc;
        mask = reduced_axes(mode_reg);
        first = 1;
        done = 1;
        last_all = 1;
        out_index = 0;
        for (int i = 0; i < 4; i++)
        begin
            dims[i] = clamp_dim(count_reg[i]);
            pos[i] = (coord[i] < dims[i]) ? coord[i] : 0;
            at_end = (pos[i] + 1 == dims[i]);
            if (mask[3 - i])
            begin
                kext[i] = 1;
                kpos[i] = 0;
                if (pos[i] != 0)
                    first = 0;
                if (!at_end)
                    done = 0;
            end
            else
            begin
                kext[i] = dims[i];
                kpos[i] = pos[i];
            end
            if (!at_end)
                last_all = 0;
        end
        for (int i = 0; i < 4; i++)
            out_index = out_index * kext[i] + kpos[i];
        addr = 32'(out_index % STORE_DEPTH);
        acc = x;
        if (!first && order_key(max_store[addr]) > order_key(x))
            acc = max_store[addr];
        max_store[addr] = acc;
        for (int i = 3; i >= 0; i--)
        begin
            pos[i] = pos[i] + 1;
            if (pos[i] < dims[i])
                break;
            pos[i] = 0;
        end
        for (int i = 0; i < 4; i++)
            coord[i] = pos[i];
        emits = done;
        res.max_bits = acc;
        res.final_result = last_all;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at cycle %0d: %s got %h expected %h", cycle_count, what, got,
                 want);
        error_count++;
    endtask

    always @(posedge clk)
    begin
        max_result_t want;
        if (out_if.valid && out_if.ready)
        begin
            results_seen++;
            if (pending_max.size() == 0)
                report_mismatch("unexpected result max_bits", out_if.max_bits, 32'h0);
            else
            begin
                want = pending_max.pop_front();
                if (out_if.max_bits !== want.max_bits)
                    report_mismatch("max_bits", out_if.max_bits, want.max_bits);
                if (out_if.final_result !== want.final_result)
                    report_mismatch("final_result", 32'(out_if.final_result),
                                    32'(want.final_result));
            end
        end
    end

    always @(posedge clk)
    begin
        int hold_left;
        if (hold_request)
        begin
            hold_request = 0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_if.ready <= 1'b0;
        end
        else
            out_if.ready <= ($urandom_range(99) >= idle_out_pct);
    end

    function automatic logic [ELEM_W-1:0] random_element();
        logic [31:0] v;
        case ($urandom_range(3))
            0: v = $urandom;
            1: v = {1'($urandom_range(1)), 8'd127 + 8'($urandom_range(3)),
                    23'($urandom_range(7))};
            2: v = {1'b1, 31'($urandom)};
            default: v = {1'b0, 31'($urandom)};
        endcase
        if (v[30:23] == 8'hFF)
            v[22:0] = 23'd0;
        if (v == 32'h8000_0000)
            v = 32'h0;
        return v;
    endfunction

    task automatic send_element(input logic [ELEM_W-1:0] x, input bit use_row,
                                input max_result_t row_result);
        bit          emits;
        max_result_t res;
        in_if.valid <= 1'b1;
        in_if.element_bits <= x;
        do
            @(posedge clk);
        while (!in_if.ready);
        items_sent++;
        update_max(x, emits, res);
        if (use_row)
            pending_max.push_back(row_result);
        else if (emits)
            pending_max.push_back(res);
        if ($urandom_range(99) < idle_in_pct)
        begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic settle();
        in_if.valid <= 1'b0;
        while (pending_max.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic configure(input logic [2:0] m, input logic [12:0] n,
                             input logic [12:0] c, input logic [12:0] h,
                             input logic [12:0] w);
        logic [CFG_DATA_W-1:0] vals [5];
        logic [CFG_IDX_W-1:0]  idx [5];
        vals = '{13'(m), n, c, h, w};
        idx = '{REG_REDUCE_MODE, REG_BATCH_COUNT, REG_CHANNEL_COUNT, REG_ROW_COUNT,
                REG_COLUMN_COUNT};
        settle();
        for (int i = 0; i < 5; i++)
        begin
            cfg_if.valid <= 1'b1;
            cfg_if.index <= idx[i];
            cfg_if.data <= vals[i];
            do
                @(posedge clk);
            while (!cfg_if.ready);
            if (idx[i] == REG_REDUCE_MODE)
                mode_reg = vals[i][2:0];
            else
                count_reg[idx[i] - 1] = vals[i];
            for (int k = 0; k < 4; k++)
                coord[k] = 0;
            config_count++;
        end
        cfg_if.valid <= 1'b0;
    endtask

    task automatic send_tensor(input int count);
        max_result_t none;
        none = '{32'h0, 1'b0};
        for (int i = 0; i < count; i++)
            send_element(random_element(), 0, none);
    endtask

    function automatic int tensor_size();
        int s;
        s = 1;
        for (int i = 0; i < 4; i++)
            s = s * clamp_dim(count_reg[i]);
        return s;
    endfunction

    function automatic logic [12:0] random_count(input int hi);
        if ($urandom_range(9) == 0)
            return 13'd0;
        return 13'($urandom_range(1, hi));
    endfunction

    task automatic random_phase(input int target);
        int stop_at;
        stop_at = items_sent + target;
        while (items_sent < stop_at)
        begin
            configure(3'($urandom_range(7)), random_count(3), random_count(3),
                      random_count(5), random_count(5));
            repeat ($urandom_range(1, 3)) send_tensor(tensor_size());
        end
    endtask

    directed_row_t directed_rows [] = '{
        '{32'h0000_0000, 32'h0000_0000}, '{32'h7F7F_FFFF, 32'h7F7F_FFFF},
        '{32'hFF7F_FFFF, 32'hFF7F_FFFF}, '{32'h7F80_0000, 32'h7F80_0000},
        '{32'hFF80_0000, 32'hFF80_0000}, '{32'h0000_0001, 32'h0000_0001},
        '{32'h8000_0001, 32'h8000_0001}, '{32'h0080_0000, 32'h0080_0000},
        '{32'h3F80_0000, 32'h3F80_0000}, '{32'hBF80_0000, 32'hBF80_0000},
        '{32'h007F_FFFF, 32'h007F_FFFF}, '{32'hAAAA_AAAA, 32'hAAAA_AAAA},
        '{32'h5555_5555, 32'h5555_5555}
    };

    initial
    begin
        max_result_t row;
        rst_n = 1'b0;
        cycle_count = 0;
        error_count = 0;
        items_sent = 0;
        results_seen = 0;
        config_count = 0;
        idle_in_pct = 0;
        idle_out_pct = 0;
        hold_request = 0;
        cfg_if.valid = 1'b0;
        cfg_if.index = REG_REDUCE_MODE;
        cfg_if.data = '0;
        in_if.valid = 1'b0;
        in_if.element_bits = '0;
        out_if.ready = 1'b0;
        mode_reg = MODE_N;
        for (int i = 0; i < 4; i++)
        begin
            count_reg[i] = 13'd1;
            coord[i] = 0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // After reset every element is its own output position and the last one.
        foreach (directed_rows[i])
        begin
            row = '{directed_rows[i].max_bits, 1'b1};
            send_element(directed_rows[i].element_bits, 1, row);
        end
        // A write in mid tensor restarts it at the first element.
        configure(MODE_ALL, 13'd0, 13'd1, 13'd1, 13'd3);
        send_tensor(2);
        configure(MODE_ALL, 13'd0, 13'd1, 13'd1, 13'd3);
        send_tensor(3);
        configure(MODE_HW, 13'd1, 13'd2, 13'd2, 13'd2);
        send_tensor(8);

        idle_in_pct = 26;
        idle_out_pct = 73;
        random_phase(280);
        configure(MODE_W, 13'd2, 13'd2, 13'd10, 13'd1);
        idle_in_pct = 0;
        hold_request = 1;
        send_tensor(tensor_size());
        idle_in_pct = 26;
        random_phase(280);

        idle_in_pct = 73;
        idle_out_pct = 26;
        random_phase(560);

        idle_in_pct = 0;
        idle_out_pct = 0;
        random_phase(560);

        settle();
        repeat (20) @(posedge clk);
        $display("Sent %0d elements over %0d register writes in all eight reduce modes,",
                 items_sent, config_count);
        $display("checked %0d result beats with %0d mismatches.", results_seen,
                 error_count);
        if (error_count == 0 && pending_max.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
